// ----- sv/tlik_pkg.sv -----
package tlik_pkg;

	localparam int ANGLE_FRAC_BITS_DEF   = 7;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	localparam int DIST_W  = 16;
	localparam int LEN_W   = 11;
	localparam int ANGLE_W = 15;

	// c is Q30, magnitude up to 2^30
	localparam int CMAG_W  = 31;
	localparam int C_W     = CMAG_W + 1;
	localparam int DEN_W   = 32;
	localparam int REM_W   = DEN_W + 1;
	localparam int CSQ_W   = 2 * CMAG_W - 1;
	localparam int SQV_W   = 2 * CMAG_W;
	localparam int SQR_W   = CMAG_W + 2;

	localparam int CW      = 46;
	localparam int ZW      = 34;
	localparam int ATAN_W  = 31;
	localparam int ATAN_LEN = 24;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(100);

	// register stages besides the cordic iterations
	localparam int LAT_FIXED = 2 + CMAG_W + 1 + CMAG_W + 2 + 2 + 1;

	typedef enum logic [0:0] {
		REG_UPPER_LINK = 1'b0,
		REG_LOWER_LINK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic valid;
		logic unr;
	} tlik_ctl_t;

	// atan(2^-i) in degrees, Q24
	function automatic logic [ATAN_W-1:0] atan_q24(input int idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			0:  v = 31'd754974720;
			1:  v = 31'd445687602;
			2:  v = 31'd235489088;
			3:  v = 31'd119537938;
			4:  v = 31'd60000934;
			5:  v = 31'd30029717;
			6:  v = 31'd15018523;
			7:  v = 31'd7509720;
			8:  v = 31'd3754917;
			9:  v = 31'd1877466;
			10: v = 31'd938734;
			11: v = 31'd469367;
			12: v = 31'd234684;
			13: v = 31'd117342;
			14: v = 31'd58671;
			15: v = 31'd29335;
			16: v = 31'd14668;
			17: v = 31'd7334;
			18: v = 31'd3667;
			19: v = 31'd1833;
			20: v = 31'd917;
			21: v = 31'd458;
			22: v = 31'd229;
			23: v = 31'd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/two_link_arm_inverse_kinematics_unit.sv -----
// throughput: one target per cycle, busy stays low; results cannot be held off
// depth is set by the pipelined divider (31 stages), root (31) and cordic lanes
// reset: asynchronous active-low, clears all valid bits and sets both link
// lengths to 100; results in flight at reset are dropped
module two_link_arm_inverse_kinematics_unit #(
	parameter int ANGLE_FRAC_BITS   = tlik_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [tlik_pkg::DIST_W-1:0] target_distance,
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [tlik_pkg::LEN_W-1:0]     cfg_wdata,
	output logic                           done,
	output logic [tlik_pkg::ANGLE_W-1:0]   shoulder_angle,
	output logic [tlik_pkg::ANGLE_W-1:0]   elbow_angle,
	output logic                           unreachable
);
	import tlik_pkg::*;

	localparam int AW = 9 + ANGLE_FRAC_BITS;
	localparam logic [AW-1:0] ANG_LIM = AW'(180) << ANGLE_FRAC_BITS;

	logic [LEN_W-1:0] upper_q;
	logic [LEN_W-1:0] lower_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= LEN_RESET;
			lower_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_UPPER_LINK: upper_q <= cfg_wdata;
				REG_LOWER_LINK: lower_q <= cfg_wdata;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: squares and reach test
	logic [LEN_W:0]      len_sum;
	logic [LEN_W-1:0]    len_diff;
	logic                unr_now;
	tlik_ctl_t           ctl_s1;
	logic [2*DIST_W-3:0] dd_s1;
	logic [2*LEN_W-1:0]  ll1_s1;
	logic [2*LEN_W-1:0]  ll2_s1;
	logic [2*LEN_W-1:0]  l12_s1;

	assign len_sum  = {1'b0, upper_q} + {1'b0, lower_q};
	assign len_diff = (upper_q > lower_q) ? upper_q - lower_q : lower_q - upper_q;
	assign unr_now  = (upper_q == '0) || (lower_q == '0) || target_distance[DIST_W-1]
		|| ({1'b0, target_distance} > {1'b0, len_sum, 4'b0000})
		|| ({1'b0, target_distance} < {2'b00, len_diff, 4'b0000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '{valid: start, unr: unr_now};
		end
	end

	always_ff @(posedge clk) begin
		dd_s1  <= target_distance[DIST_W-2:0] * target_distance[DIST_W-2:0];
		ll1_s1 <= upper_q * upper_q;
		ll2_s1 <= lower_q * lower_q;
		l12_s1 <= upper_q * lower_q;
	end

	// stage 2: cosine-law numerator and denominator
	logic [2*LEN_W:0]  llsum;
	logic [DEN_W:0]    numv;
	tlik_ctl_t         ctl_s2;
	logic [DEN_W-1:0]  num_s2;
	logic [DEN_W-1:0]  den_s2;
	logic              neg_s2;

	assign llsum = {1'b0, ll1_s1} + {1'b0, ll2_s1};
	assign numv  = {3'b000, dd_s1} - {2'b00, llsum, 8'h00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s2 <= numv[DEN_W];
		num_s2 <= numv[DEN_W] ? DEN_W'(-numv) : numv[DEN_W-1:0];
		den_s2 <= {1'b0, l12_s1, 9'h000};
	end

	tlik_ctl_t          div_ctl;
	logic [CMAG_W-1:0]  div_quo;
	logic               div_neg;

	tlik_div #(.PASS_W(1)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_s2),
		.in_num   (num_s2),
		.in_den   (den_s2),
		.in_pass  (neg_s2),
		.out_ctl  (div_ctl),
		.out_quo  (div_quo),
		.out_pass (div_neg)
	);

	// stage 3: signed cosine and its square
	tlik_ctl_t             ctl_s3;
	logic signed [C_W-1:0] c_s3;
	logic [CSQ_W-1:0]      csq_s3;
	logic [2*CMAG_W-1:0]   qq;

	assign qq = div_quo * div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= div_ctl;
		end
	end

	always_ff @(posedge clk) begin
		c_s3   <= div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		csq_s3 <= qq[CSQ_W-1:0];
	end

	logic [SQV_W-1:0]  sq_val;
	tlik_ctl_t         sq_ctl;
	logic [CMAG_W-1:0] sq_root;
	logic [C_W-1:0]    sq_c;

	assign sq_val = (SQV_W'(1) << (2 * (CMAG_W - 1))) - {1'b0, csq_s3};

	tlik_isqrt #(.PASS_W(C_W)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl_s3),
		.in_val   (sq_val),
		.in_pass  (c_s3),
		.out_ctl  (sq_ctl),
		.out_root (sq_root),
		.out_pass (sq_c)
	);

	// stage 4: link projections
	tlik_ctl_t                        ctl_s4;
	logic [LEN_W+CMAG_W-1:0]          ly_s4;
	logic signed [LEN_W+1+C_W-1:0]    lc_s4;
	logic signed [C_W-1:0]            c_s4;
	logic [CMAG_W-1:0]                s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= sq_ctl;
		end
	end

	always_ff @(posedge clk) begin
		ly_s4 <= lower_q * sq_root;
		lc_s4 <= $signed({1'b0, lower_q}) * $signed(sq_c);
		c_s4  <= $signed(sq_c);
		s_s4  <= sq_root;
	end

	// stage 5: cordic operands
	tlik_ctl_t            ctl_s5;
	logic signed [CW-1:0] x_s5 [2];
	logic signed [CW-1:0] y_s5 [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s5[0] <= $signed({{(CW-LEN_W-CMAG_W+1){1'b0}}, upper_q, {(CMAG_W-1){1'b0}}})
			+ CW'(lc_s4);
		y_s5[0] <= $signed({{(CW-LEN_W-CMAG_W){1'b0}}, ly_s4});
		x_s5[1] <= CW'(c_s4);
		y_s5[1] <= $signed({{(CW-CMAG_W){1'b0}}, s_s4});
	end

	tlik_ctl_t     cor_ctl;
	logic [AW-1:0] cor_angle [2];

	tlik_cordic #(
		.ITER (CORDIC_ITERATIONS),
		.FRAC (ANGLE_FRAC_BITS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (ctl_s5),
		.in_x      (x_s5),
		.in_y      (y_s5),
		.out_ctl   (cor_ctl),
		.out_angle (cor_angle)
	);

	// result register
	logic                done_q;
	logic [ANGLE_W-1:0]  shoulder_q;
	logic [ANGLE_W-1:0]  elbow_q;
	logic                unr_q;
	logic [AW-1:0]       elbow_full;

	assign elbow_full = ANG_LIM - cor_angle[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cor_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		unr_q      <= cor_ctl.unr;
		shoulder_q <= cor_ctl.unr ? '0 : ANGLE_W'(cor_angle[0]);
		elbow_q    <= cor_ctl.unr ? '0 : ANGLE_W'(elbow_full);
	end

	assign done           = done_q;
	assign shoulder_angle = shoulder_q;
	assign elbow_angle    = elbow_q;
	assign unreachable    = unr_q;

endmodule

// ----- sv/tlik_div.sv -----
module tlik_div #(
	parameter int PASS_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tlik_pkg::tlik_ctl_t       in_ctl,
	input  logic [tlik_pkg::DEN_W-1:0]  in_num,
	input  logic [tlik_pkg::DEN_W-1:0]  in_den,
	input  logic [PASS_W-1:0]         in_pass,
	output tlik_pkg::tlik_ctl_t       out_ctl,
	output logic [tlik_pkg::CMAG_W-1:0] out_quo,
	output logic [PASS_W-1:0]         out_pass
);
	import tlik_pkg::*;

	// one quotient bit per stage, msb first; user keeps numerator <= denominator
	tlik_ctl_t          ctl_s  [CMAG_W];
	logic [REM_W-1:0]   rem_s  [CMAG_W];
	logic [CMAG_W-1:0]  quo_s  [CMAG_W];
	logic [DEN_W-1:0]   den_s  [CMAG_W];
	logic [PASS_W-1:0]  pass_s [CMAG_W];

	for (genvar k = 0; k < CMAG_W; k++) begin : g_stage
		tlik_ctl_t         ctl_in;
		logic [REM_W-1:0]  rem_in;
		logic [CMAG_W-1:0] quo_in;
		logic [DEN_W-1:0]  den_in;
		logic [PASS_W-1:0] pass_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign ctl_in  = in_ctl;
			assign rem_in  = {1'b0, in_num};
			assign quo_in  = '0;
			assign den_in  = in_den;
			assign pass_in = in_pass;
		end else begin : g_rest
			assign ctl_in  = ctl_s[k-1];
			assign rem_in  = {rem_s[k-1][REM_W-2:0], 1'b0};
			assign quo_in  = quo_s[k-1];
			assign den_in  = den_s[k-1];
			assign pass_in = pass_s[k-1];
		end

		assign ge = rem_in >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? rem_in - {1'b0, den_in} : rem_in;
			quo_s[k]  <= {quo_in[CMAG_W-2:0], ge};
			den_s[k]  <= den_in;
			pass_s[k] <= pass_in;
		end
	end

	assign out_ctl  = ctl_s[CMAG_W-1];
	assign out_quo  = quo_s[CMAG_W-1];
	assign out_pass = pass_s[CMAG_W-1];

endmodule

// ----- sv/tlik_isqrt.sv -----
module tlik_isqrt #(
	parameter int PASS_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tlik_pkg::tlik_ctl_t         in_ctl,
	input  logic [tlik_pkg::SQV_W-1:0]  in_val,
	input  logic [PASS_W-1:0]           in_pass,
	output tlik_pkg::tlik_ctl_t         out_ctl,
	output logic [tlik_pkg::CMAG_W-1:0] out_root,
	output logic [PASS_W-1:0]           out_pass
);
	import tlik_pkg::*;

	localparam int STAGES = SQV_W / 2;

	// digit-by-digit root, two radicand bits per stage
	tlik_ctl_t          ctl_s  [STAGES];
	logic [SQV_W-1:0]   val_s  [STAGES];
	logic [SQR_W-1:0]   rem_s  [STAGES];
	logic [CMAG_W-1:0]  root_s [STAGES];
	logic [PASS_W-1:0]  pass_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		tlik_ctl_t         ctl_in;
		logic [SQV_W-1:0]  val_in;
		logic [SQR_W-1:0]  rem_in;
		logic [CMAG_W-1:0] root_in;
		logic [PASS_W-1:0] pass_in;
		logic [SQR_W+1:0]  acc;
		logic [SQR_W+1:0]  trial;
		logic              ge;
		logic [SQR_W+1:0]  diff;

		if (k == 0) begin : g_first
			assign ctl_in  = in_ctl;
			assign val_in  = in_val;
			assign rem_in  = '0;
			assign root_in = '0;
			assign pass_in = in_pass;
		end else begin : g_rest
			assign ctl_in  = ctl_s[k-1];
			assign val_in  = val_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign pass_in = pass_s[k-1];
		end

		assign acc   = {rem_in, val_in[SQV_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = acc >= trial;
		assign diff  = ge ? acc - trial : acc;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			val_s[k]  <= {val_in[SQV_W-3:0], 2'b00};
			rem_s[k]  <= diff[SQR_W-1:0];
			root_s[k] <= {root_in[CMAG_W-2:0], ge};
			pass_s[k] <= pass_in;
		end
	end

	assign out_ctl  = ctl_s[STAGES-1];
	assign out_root = root_s[STAGES-1];
	assign out_pass = pass_s[STAGES-1];

endmodule

// ----- sv/tlik_cordic.sv -----
module tlik_cordic #(
	parameter int ITER = tlik_pkg::CORDIC_ITERATIONS_DEF,
	parameter int FRAC = tlik_pkg::ANGLE_FRAC_BITS_DEF,
	localparam int AW  = 9 + FRAC
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tlik_pkg::tlik_ctl_t          in_ctl,
	input  logic signed [tlik_pkg::CW-1:0] in_x [2],
	input  logic signed [tlik_pkg::CW-1:0] in_y [2],
	output tlik_pkg::tlik_ctl_t          out_ctl,
	output logic [AW-1:0]                out_angle [2]
);
	import tlik_pkg::*;

	localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90) <<< 24;
	localparam logic [ZW-1:0]        RND       = ZW'(1) << (23 - FRAC);
	localparam logic [ZW-1:0]        LIM       = ZW'(180) << FRAC;

	tlik_ctl_t             ctl_s [ITER+1];
	logic signed [CW-1:0]  x_s   [ITER+1][2];
	logic signed [CW-1:0]  y_s   [ITER+1][2];
	logic signed [ZW-1:0]  z_s   [ITER+1][2];
	tlik_ctl_t             ctl_out_q;
	logic [AW-1:0]         angle_q [2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out_q <= '0;
		end else begin
			ctl_out_q <= ctl_s[ITER];
		end
	end

	for (genvar i = 0; i <= ITER; i++) begin : g_ctl
		if (i == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctl_s[i] <= '0;
				end else begin
					ctl_s[i] <= in_ctl;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctl_s[i] <= '0;
				end else begin
					ctl_s[i] <= ctl_s[i-1];
				end
			end
		end
	end

	for (genvar ln = 0; ln < 2; ln++) begin : g_lane
		// left half plane turned by a quarter
		always_ff @(posedge clk) begin
			if (in_x[ln] < 0) begin
				x_s[0][ln] <= in_y[ln];
				y_s[0][ln] <= -in_x[ln];
				z_s[0][ln] <= Z_QUARTER;
			end else begin
				x_s[0][ln] <= in_x[ln];
				y_s[0][ln] <= in_y[ln];
				z_s[0][ln] <= '0;
			end
		end

		for (genvar i = 0; i < ITER; i++) begin : g_iter
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			logic signed [ZW-1:0] da;

			assign dx = y_s[i][ln] >>> i;
			assign dy = x_s[i][ln] >>> i;
			assign da = $signed({{(ZW-ATAN_W){1'b0}}, atan_q24(i)});

			always_ff @(posedge clk) begin
				if (y_s[i][ln] > 0) begin
					x_s[i+1][ln] <= x_s[i][ln] + dx;
					y_s[i+1][ln] <= y_s[i][ln] - dy;
					z_s[i+1][ln] <= z_s[i][ln] + da;
				end else begin
					x_s[i+1][ln] <= x_s[i][ln] - dx;
					y_s[i+1][ln] <= y_s[i][ln] + dy;
					z_s[i+1][ln] <= z_s[i][ln] - da;
				end
			end
		end

		logic [ZW-1:0] zc;
		logic [ZW-1:0] zr;

		assign zc = z_s[ITER][ln][ZW-1] ? '0 : z_s[ITER][ln];
		assign zr = (zc + RND) >> (24 - FRAC);

		always_ff @(posedge clk) begin
			angle_q[ln] <= (zr > LIM) ? LIM[AW-1:0] : zr[AW-1:0];
		end

		assign out_angle[ln] = angle_q[ln];
	end

	assign out_ctl = ctl_out_q;

endmodule

// ----- sv/tlik_checker.sv -----
module tlik_checker #(
	parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITERATIONS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic [tlik_pkg::DIST_W-1:0]      target_distance,
	input logic                             done,
	input logic [tlik_pkg::ANGLE_W-1:0]     shoulder_angle,
	input logic [tlik_pkg::ANGLE_W-1:0]     elbow_angle,
	input logic                             unreachable
);
	import tlik_pkg::*;

	localparam int LATENCY = LAT_FIXED + CORDIC_ITERATIONS;
	localparam int CNT_W   = $clog2(LATENCY + 1);

	// cycles since reset, saturating, so history checks skip the flushed window
	logic [CNT_W-1:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CNT_W'(LATENCY)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == CNT_W'(LATENCY)) |-> (done == $past(start && !busy, LATENCY)))
		else $error("result beat does not follow its start by the pipeline latency");

	a_negative: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == CNT_W'(LATENCY)) && done
		&& $past(target_distance[DIST_W-1], LATENCY) |-> unreachable)
		else $error("negative target not flagged unreachable");

	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		done && unreachable |-> (shoulder_angle == '0) && (elbow_angle == '0))
		else $error("unreachable beat carries nonzero angles");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a fully pipelined unit");

endmodule

bind two_link_arm_inverse_kinematics_unit tlik_checker #(
	.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
) u_tlik_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.target_distance (target_distance),
	.done            (done),
	.shoulder_angle  (shoulder_angle),
	.elbow_angle     (elbow_angle),
	.unreachable     (unreachable)
);
